>>> hdl/mlfq_pkg.sv
// Shared constants, command codes and field layout for the multilevel feedback
// queue scheduler core. No dependencies.
package mlfq_pkg;

    localparam int NUM_LEVELS    = 5;
    localparam int MAX_PROCESSES = 16;

    localparam int CMD_W   = 3;
    localparam int ID_W    = 4;
    localparam int PRIO_W  = 3;
    localparam int TIME_W  = 16;
    localparam int LVL_W   = $clog2(NUM_LEVELS);
    localparam int HEAD_W  = $clog2(MAX_PROCESSES);
    localparam int CNT_W   = $clog2(MAX_PROCESSES + 1);
    localparam int RAM_DEPTH = NUM_LEVELS * MAX_PROCESSES;
    localparam int RAM_AW  = $clog2(RAM_DEPTH);

    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 8;

    localparam logic [CMD_W-1:0] CMD_NEW     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TIMER   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_IO_REQ  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_IO_DONE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FINISH  = 3'd4;

    localparam logic [LVL_W-1:0] TOP_LEVEL = LVL_W'(NUM_LEVELS - 1);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_PREP = 6'b000010,
        ST_ENQ  = 6'b000100,
        ST_SCAN = 6'b001000,
        ST_READ = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

endpackage

>>> hdl/mlfq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependency.
module mlfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/multilevel_feedback_queue_scheduler_core.sv
// Top level of the multilevel feedback queue scheduler core.
// Depends on mlfq_pkg and mlfq_ram (queue entry storage).
//
// Usage: one scheduling event is a transfer on the s_ group; exactly one
// decision comes back as a transfer on the m_ group. Events carry a command
// (new process, timer tick, I/O request, I/O done, finished), the process
// concerned, the running process and the system time. The result names the
// process to run next, or none.
// A small sequencer works through each event with one shared level pointer:
// a decode step, an optional enqueue step and, for a dispatch, a scan over
// the ready queues one level per cycle from the scan level upwards and a
// queue RAM read step when a queue holds a process.
// s_tready is high only while the sequencer is idle, so the next event is
// taken once the previous one is finished.
// A finished result sits in the output register; the next event may be taken
// while it waits, and the sequencer holds its next result until m_tready
// frees the register.
// Reset empties all queues and sets the scan level to zero; s_tready is high
// as soon as reset is released.
module multilevel_feedback_queue_scheduler_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command[2:0], process_id[6:3], initial_priority[9:7], running_id[13:10],
    // running_valid[14], tick_time[30:15], zero[31]
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // next_id[3:0], next_valid[4], zero[7:5]
    output logic [7:0]  m_tdata
);

    localparam int LVLS = mlfq_pkg::NUM_LEVELS;
    localparam int PROCS = mlfq_pkg::MAX_PROCESSES;

    mlfq_pkg::state_t state_reg, state_next;

    logic [mlfq_pkg::CMD_W-1:0]  cmd_reg, cmd_next;
    logic [mlfq_pkg::ID_W-1:0]   pid_reg, pid_next;
    logic [mlfq_pkg::PRIO_W-1:0] iprio_reg, iprio_next;
    logic [mlfq_pkg::ID_W-1:0]   rid_reg, rid_next;
    logic                        rvalid_reg, rvalid_next;
    logic                        tzero_reg, tzero_next;

    logic                        enq_reg, enq_next;
    logic                        disp_reg, disp_next;
    logic [mlfq_pkg::LVL_W-1:0]  lvl_reg, lvl_next;
    logic [mlfq_pkg::LVL_W-1:0]  scan_reg, scan_next;

    logic [mlfq_pkg::HEAD_W-1:0] head_reg [LVLS];
    logic [mlfq_pkg::HEAD_W-1:0] head_next [LVLS];
    logic [mlfq_pkg::CNT_W-1:0]  count_reg [LVLS];
    logic [mlfq_pkg::CNT_W-1:0]  count_next [LVLS];
    logic [mlfq_pkg::PRIO_W-1:0] prio_reg [PROCS];
    logic [mlfq_pkg::PRIO_W-1:0] prio_next [PROCS];

    logic [mlfq_pkg::ID_W-1:0]   res_id_reg, res_id_next;
    logic                        res_valid_reg, res_valid_next;
    logic [mlfq_pkg::ID_W-1:0]   out_id_reg, out_id_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        m_tvalid_reg, m_tvalid_next;

    logic                        ram_we;
    logic [mlfq_pkg::RAM_AW-1:0] ram_waddr;
    logic [mlfq_pkg::RAM_AW-1:0] ram_raddr;
    logic [mlfq_pkg::ID_W-1:0]   ram_rdata;

    logic [mlfq_pkg::ID_W-1:0]   prio_idx;
    logic [mlfq_pkg::PRIO_W-1:0] prio_rd;
    logic [mlfq_pkg::PRIO_W:0]   prio_inc;
    logic [mlfq_pkg::LVL_W-1:0]  new_lvl;
    logic [mlfq_pkg::LVL_W-1:0]  inc_lvl;
    logic [mlfq_pkg::LVL_W-1:0]  rd_lvl;
    logic [mlfq_pkg::HEAD_W-1:0] tail_pos;

    mlfq_ram #(
        .WIDTH (mlfq_pkg::ID_W),
        .DEPTH (mlfq_pkg::RAM_DEPTH)
    ) u_queue_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (pid_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Timer events look up the running process, all others the named one.
    assign prio_idx = (cmd_reg == mlfq_pkg::CMD_TIMER) ? rid_reg : pid_reg;
    assign prio_rd  = prio_reg[prio_idx];
    assign prio_inc = {1'b0, prio_rd} + 1'b1;

    assign new_lvl = (int'(iprio_reg) >= LVLS) ? mlfq_pkg::TOP_LEVEL
                                               : mlfq_pkg::LVL_W'(iprio_reg);
    assign inc_lvl = (int'(prio_inc) >= LVLS) ? mlfq_pkg::TOP_LEVEL
                                              : mlfq_pkg::LVL_W'(prio_inc);
    assign rd_lvl  = (int'(prio_rd) >= LVLS) ? mlfq_pkg::TOP_LEVEL
                                             : mlfq_pkg::LVL_W'(prio_rd);

    assign tail_pos = head_reg[lvl_reg] + count_reg[lvl_reg][mlfq_pkg::HEAD_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        pid_next       = pid_reg;
        iprio_next     = iprio_reg;
        rid_next       = rid_reg;
        rvalid_next    = rvalid_reg;
        tzero_next     = tzero_reg;
        enq_next       = enq_reg;
        disp_next      = disp_reg;
        lvl_next       = lvl_reg;
        scan_next      = scan_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        prio_next      = prio_reg;
        res_id_next    = res_id_reg;
        res_valid_next = res_valid_reg;
        out_id_next    = out_id_reg;
        out_valid_next = out_valid_reg;
        m_tvalid_next  = m_tvalid_reg;
        ram_we         = 1'b0;
        ram_waddr      = {lvl_reg, tail_pos};
        ram_raddr      = {lvl_reg, head_reg[lvl_reg]};

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            mlfq_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next    = s_tdata[2:0];
                    pid_next    = s_tdata[6:3];
                    iprio_next  = s_tdata[9:7];
                    rid_next    = s_tdata[13:10];
                    rvalid_next = s_tdata[14];
                    tzero_next  = (s_tdata[30:15] == '0);
                    state_next  = mlfq_pkg::ST_PREP;
                end
            end

            mlfq_pkg::ST_PREP:
            begin
                enq_next       = 1'b0;
                disp_next      = 1'b0;
                res_id_next    = rvalid_reg ? rid_reg : '0;
                res_valid_next = rvalid_reg;
                unique case (cmd_reg)
                    mlfq_pkg::CMD_NEW:
                    begin
                        if (int'(pid_reg) < PROCS)
                        begin
                            prio_next[pid_reg] = mlfq_pkg::PRIO_W'(new_lvl);
                            if (scan_reg > new_lvl)
                            begin
                                scan_next = new_lvl;
                            end
                            lvl_next = new_lvl;
                            enq_next = 1'b1;
                        end
                        disp_next = tzero_reg;
                    end
                    mlfq_pkg::CMD_TIMER:
                    begin
                        if (rvalid_reg && (int'(rid_reg) < PROCS))
                        begin
                            prio_next[rid_reg] = mlfq_pkg::PRIO_W'(inc_lvl);
                            lvl_next = inc_lvl;
                            enq_next = 1'b1;
                        end
                        disp_next = 1'b1;
                    end
                    mlfq_pkg::CMD_IO_REQ, mlfq_pkg::CMD_FINISH:
                    begin
                        disp_next = 1'b1;
                    end
                    mlfq_pkg::CMD_IO_DONE:
                    begin
                        if (int'(pid_reg) < PROCS)
                        begin
                            lvl_next = rd_lvl;
                            enq_next = 1'b1;
                            if (int'(scan_reg) > int'(prio_rd))
                            begin
                                scan_next = mlfq_pkg::LVL_W'(prio_rd);
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
                state_next = mlfq_pkg::ST_ENQ;
            end

            mlfq_pkg::ST_ENQ:
            begin
                // The enqueue id is the captured process id except for a timer
                // event, which re-enqueues the running process.
                if (enq_reg && (int'(count_reg[lvl_reg]) < PROCS))
                begin
                    ram_we = 1'b1;
                    count_next[lvl_reg] = count_reg[lvl_reg] + 1'b1;
                end
                lvl_next = scan_reg;
                state_next = disp_reg ? mlfq_pkg::ST_SCAN : mlfq_pkg::ST_DONE;
            end

            mlfq_pkg::ST_SCAN:
            begin
                priority if (count_reg[lvl_reg] != '0)
                begin
                    head_next[lvl_reg]  = head_reg[lvl_reg] + 1'b1;
                    count_next[lvl_reg] = count_reg[lvl_reg] - 1'b1;
                    scan_next  = lvl_reg;
                    state_next = mlfq_pkg::ST_READ;
                end
                else if (lvl_reg == mlfq_pkg::TOP_LEVEL)
                begin
                    scan_next      = '0;
                    res_id_next    = '0;
                    res_valid_next = 1'b0;
                    state_next     = mlfq_pkg::ST_DONE;
                end
                else
                begin
                    lvl_next = lvl_reg + 1'b1;
                end
            end

            mlfq_pkg::ST_READ:
            begin
                res_id_next    = ram_rdata;
                res_valid_next = 1'b1;
                state_next     = mlfq_pkg::ST_DONE;
            end

            mlfq_pkg::ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_id_next    = res_id_reg;
                    out_valid_next = res_valid_reg;
                    m_tvalid_next  = 1'b1;
                    state_next     = mlfq_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = mlfq_pkg::ST_IDLE;
            end
        endcase
    end

    // Timer events write the running id into the queue; move it into the
    // shared id register once decode has used the named id.
    logic [mlfq_pkg::ID_W-1:0] pid_final;
    assign pid_final = ((state_reg == mlfq_pkg::ST_PREP) && (cmd_reg == mlfq_pkg::CMD_TIMER))
                       ? rid_reg : pid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= mlfq_pkg::ST_IDLE;
            scan_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < LVLS; i++)
            begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            scan_reg     <= scan_next;
            m_tvalid_reg <= m_tvalid_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        pid_reg       <= pid_final;
        iprio_reg     <= iprio_next;
        rid_reg       <= rid_next;
        rvalid_reg    <= rvalid_next;
        tzero_reg     <= tzero_next;
        enq_reg       <= enq_next;
        disp_reg      <= disp_next;
        lvl_reg       <= lvl_next;
        prio_reg      <= prio_next;
        res_id_reg    <= res_id_next;
        res_valid_reg <= res_valid_next;
        out_id_reg    <= out_id_next;
        out_valid_reg <= out_valid_next;
    end

    assign s_tready = (state_reg == mlfq_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, out_valid_reg, out_id_reg};

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the multilevel feedback queue scheduler core.
// Depends on mlfq_pkg and the core; it predicts every scheduling decision and
// compares it with each result transfer.
module testbench;

    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int CMD_LAST     = (1 << mlfq_pkg::CMD_W) - 1;

    // Packed so that command lands in the lowest bits of s_tdata.
    typedef struct packed {
        logic [mlfq_pkg::TIME_W-1:0] tick_time;
        logic                        running_valid;
        logic [mlfq_pkg::ID_W-1:0]   running_id;
        logic [mlfq_pkg::PRIO_W-1:0] initial_priority;
        logic [mlfq_pkg::ID_W-1:0]   process_id;
        logic [mlfq_pkg::CMD_W-1:0]  command;
    } sched_event_t;

    typedef struct packed {
        logic                      next_valid;
        logic [mlfq_pkg::ID_W-1:0] next_id;
    } sched_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;

    multilevel_feedback_queue_scheduler_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predicted scheduler state.
    logic [mlfq_pkg::ID_W-1:0]   ready_store [mlfq_pkg::NUM_LEVELS][mlfq_pkg::MAX_PROCESSES];
    int                          ready_head [mlfq_pkg::NUM_LEVELS];
    int                          ready_count [mlfq_pkg::NUM_LEVELS];
    logic [mlfq_pkg::PRIO_W-1:0] proc_level [mlfq_pkg::MAX_PROCESSES];
    logic [mlfq_pkg::MAX_PROCESSES-1:0] level_known = '0;
    int                          scan_from = 0;

    sched_result_t             decision_q[$];
    logic [mlfq_pkg::ID_W-1:0] running_now_id = '0;
    logic                      running_now_valid = 1'b0;
    int unsigned               mismatch_count = 0;
    int unsigned               quiet_cycles = 0;
    int unsigned               tx_idle_pct = 0;
    int unsigned               rx_idle_pct = 0;
    int unsigned               rx_hold_req = 0;
    int unsigned               rx_hold_left = 0;

    initial
    begin
        for (int lvl = 0; lvl < mlfq_pkg::NUM_LEVELS; lvl++)
        begin
            ready_head[lvl] = 0;
            ready_count[lvl] = 0;
        end
    end

    function automatic void ready_push(logic [mlfq_pkg::ID_W-1:0] id);
        int lvl;
        int pos;
        lvl = int'(proc_level[id]);
        if (lvl >= mlfq_pkg::NUM_LEVELS)
            lvl = mlfq_pkg::NUM_LEVELS - 1;
        // A full queue silently drops the process.
        if (ready_count[lvl] >= mlfq_pkg::MAX_PROCESSES)
            return;
        pos = (ready_head[lvl] + ready_count[lvl]) % mlfq_pkg::MAX_PROCESSES;
        ready_store[lvl][pos] = id;
        ready_count[lvl]++;
    endfunction

    function automatic void scan_lower(logic [mlfq_pkg::ID_W-1:0] id);
        if (scan_from > int'(proc_level[id]))
            scan_from = int'(proc_level[id]);
    endfunction

    function automatic sched_result_t ready_pop();
        sched_result_t r;
        logic          found;
        r = '0;
        found = 1'b0;
        for (int lvl = scan_from; lvl < mlfq_pkg::NUM_LEVELS; lvl++)
        begin
            if (!found && ready_count[lvl] != 0)
            begin
                r.next_id = ready_store[lvl][ready_head[lvl]];
                r.next_valid = 1'b1;
                ready_head[lvl] = (ready_head[lvl] + 1) % mlfq_pkg::MAX_PROCESSES;
                ready_count[lvl]--;
                scan_from = lvl;
                found = 1'b1;
            end
        end
        if (!found)
            scan_from = 0;
        return r;
    endfunction

    function automatic sched_result_t schedule_event(sched_event_t ev);
        sched_result_t r;
        int            lvl;
        logic          run_dispatch;
        r.next_valid = ev.running_valid;
        r.next_id = ev.running_valid ? ev.running_id : '0;
        run_dispatch = 1'b0;
        case (ev.command)
            mlfq_pkg::CMD_NEW:
            begin
                lvl = int'(ev.initial_priority);
                if (lvl >= mlfq_pkg::NUM_LEVELS)
                    lvl = mlfq_pkg::NUM_LEVELS - 1;
                proc_level[ev.process_id] = mlfq_pkg::PRIO_W'(lvl);
                level_known[ev.process_id] = 1'b1;
                scan_lower(ev.process_id);
                ready_push(ev.process_id);
                run_dispatch = (ev.tick_time == '0);
            end
            mlfq_pkg::CMD_TIMER:
            begin
                if (ev.running_valid)
                begin
                    lvl = int'(proc_level[ev.running_id]) + 1;
                    if (lvl >= mlfq_pkg::NUM_LEVELS)
                        lvl = mlfq_pkg::NUM_LEVELS - 1;
                    proc_level[ev.running_id] = mlfq_pkg::PRIO_W'(lvl);
                    level_known[ev.running_id] = 1'b1;
                    ready_push(ev.running_id);
                end
                run_dispatch = 1'b1;
            end
            mlfq_pkg::CMD_IO_REQ, mlfq_pkg::CMD_FINISH:
                run_dispatch = 1'b1;
            mlfq_pkg::CMD_IO_DONE:
            begin
                ready_push(ev.process_id);
                scan_lower(ev.process_id);
            end
            default:
                ;
        endcase
        if (run_dispatch)
            r = ready_pop();
        return r;
    endfunction

    function automatic sched_event_t make_event(logic [mlfq_pkg::CMD_W-1:0] cmd, int pid,
                                                int prio, int rid, logic rvalid, int t);
        sched_event_t ev;
        ev.command = cmd;
        ev.process_id = mlfq_pkg::ID_W'(pid);
        ev.initial_priority = mlfq_pkg::PRIO_W'(prio);
        ev.running_id = mlfq_pkg::ID_W'(rid);
        ev.running_valid = rvalid;
        ev.tick_time = mlfq_pkg::TIME_W'(t);
        return ev;
    endfunction

    // Mostly follows the predicted running process, as a real kernel would, with
    // some noise. Timer and I/O done events only name processes that have a level.
    function automatic sched_event_t random_event();
        sched_event_t ev;
        int unsigned  pick;
        ev.process_id = mlfq_pkg::ID_W'($urandom_range(mlfq_pkg::MAX_PROCESSES - 1));
        ev.initial_priority = mlfq_pkg::PRIO_W'($urandom_range((1 << mlfq_pkg::PRIO_W) - 1));
        ev.tick_time = ($urandom_range(99) < 35) ? '0
                                                 : mlfq_pkg::TIME_W'($urandom_range('hFFFF));
        if ($urandom_range(99) < 85)
        begin
            ev.running_id = running_now_id;
            ev.running_valid = running_now_valid;
        end
        else
        begin
            ev.running_id = mlfq_pkg::ID_W'($urandom_range(mlfq_pkg::MAX_PROCESSES - 1));
            ev.running_valid = 1'($urandom_range(1));
        end
        pick = $urandom_range(99);
        if (pick < 25)
            ev.command = mlfq_pkg::CMD_NEW;
        else if (pick < 55)
            ev.command = mlfq_pkg::CMD_TIMER;
        else if (pick < 65)
            ev.command = mlfq_pkg::CMD_IO_REQ;
        else if (pick < 80)
            ev.command = mlfq_pkg::CMD_IO_DONE;
        else if (pick < 93)
            ev.command = mlfq_pkg::CMD_FINISH;
        else
            ev.command = mlfq_pkg::CMD_W'($urandom_range(CMD_LAST,
                                                         int'(mlfq_pkg::CMD_FINISH) + 1));
        if (ev.command == mlfq_pkg::CMD_TIMER && ev.running_valid
            && !level_known[ev.running_id])
            ev.running_valid = 1'b0;
        if (ev.command == mlfq_pkg::CMD_IO_DONE)
        begin
            if (level_known == '0)
                ev.command = mlfq_pkg::CMD_NEW;
            else
                while (!level_known[ev.process_id])
                    ev.process_id = mlfq_pkg::ID_W'($urandom_range(mlfq_pkg::MAX_PROCESSES - 1));
        end
        return ev;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_event(input sched_event_t ev);
        sched_result_t decision;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = {1'b0, ev};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        decision = schedule_event(ev);
        decision_q.push_back(decision);
        running_now_id = decision.next_id;
        running_now_valid = decision.next_valid;
        @(negedge clk);
    endtask

    task automatic wait_all_results();
        s_tvalid = 1'b0;
        while (decision_q.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic test_idle_dispatch();
        send_event(make_event(mlfq_pkg::CMD_FINISH, 0, 0, 15, 1'b1, 'hFFFF));
        send_event(make_event(mlfq_pkg::CMD_TIMER, 15, 7, 15, 1'b0, 0));
        send_event(make_event(mlfq_pkg::CMD_IO_REQ, 0, 0, 0, 1'b0, 0));
    endtask

    task automatic test_new_process();
        send_event(make_event(mlfq_pkg::CMD_NEW, 0, 7, 15, 1'b1, 'hFFFF));
        send_event(make_event(mlfq_pkg::CMD_NEW, 15, 0, 3, 1'b0, 1));
        send_event(make_event(mlfq_pkg::CMD_NEW, 5, 4, 0, 1'b0, 0));
        send_event(make_event(mlfq_pkg::CMD_NEW, 9, 5, 15, 1'b1, 0));
    endtask

    task automatic test_timer_demotion();
        send_event(make_event(mlfq_pkg::CMD_TIMER, 0, 0, 15, 1'b1, 'hFFFF));
        send_event(make_event(mlfq_pkg::CMD_TIMER, 0, 0, 0, 1'b1, 0));
        send_event(make_event(mlfq_pkg::CMD_TIMER, 0, 0, 9, 1'b1, 0));
    endtask

    task automatic test_io_and_finish();
        send_event(make_event(mlfq_pkg::CMD_IO_REQ, 0, 0, 5, 1'b1, 0));
        send_event(make_event(mlfq_pkg::CMD_IO_DONE, 15, 7, 5, 1'b1, 'hFFFF));
        send_event(make_event(mlfq_pkg::CMD_IO_DONE, 0, 0, 0, 1'b0, 0));
        send_event(make_event(mlfq_pkg::CMD_FINISH, 0, 0, 15, 1'b1, 0));
    endtask

    task automatic test_unknown_command();
        for (int c = int'(mlfq_pkg::CMD_FINISH) + 1; c <= CMD_LAST; c++)
            send_event(make_event(mlfq_pkg::CMD_W'(c), 15, 7, 15, c[0], 'hFFFF));
    endtask

    // Seventeen arrivals at level four join the one process there and overflow by two.
    task automatic test_full_queue();
        for (int i = 0; i <= mlfq_pkg::MAX_PROCESSES; i++)
            send_event(make_event(mlfq_pkg::CMD_NEW, i, 4, 9, 1'b1, 3));
    endtask

    // The receiver stops for a long stretch while events keep coming, so the
    // output register and the sequencer both fill and s_tready drops.
    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_req = HOLD_CYCLES;
        repeat (12)
            send_event(random_event());
        wait_all_results();
    endtask

    task automatic test_random_traffic(input int unsigned n_events, input int unsigned tx_pct,
                                       input int unsigned rx_pct);
        int unsigned sent;
        int unsigned burst;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        sent = 0;
        while (sent < n_events)
        begin
            if ($urandom_range(99) < 4)
            begin
                // A run of arrivals with no dispatch fills the queues.
                burst = $urandom_range(20, 8);
                repeat (burst)
                begin
                    send_event(make_event(mlfq_pkg::CMD_NEW,
                                          int'($urandom_range(mlfq_pkg::MAX_PROCESSES - 1)),
                                          int'($urandom_range((1 << mlfq_pkg::PRIO_W) - 1)),
                                          int'(running_now_id), running_now_valid,
                                          int'($urandom_range('hFFFF, 1))));
                    sent++;
                end
            end
            else
            begin
                send_event(random_event());
                sent++;
            end
        end
        wait_all_results();
    endtask

    always @(negedge clk)
    begin
        if (rx_hold_req != 0)
        begin
            rx_hold_left = rx_hold_req;
            rx_hold_req = 0;
        end
        if (rx_hold_left != 0)
        begin
            m_tready = 1'b0;
            rx_hold_left--;
        end
        else
            m_tready = ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        sched_result_t got;
        sched_result_t want;
        if (m_tvalid && m_tready)
        begin
            got.next_id = m_tdata[mlfq_pkg::ID_W-1:0];
            got.next_valid = m_tdata[mlfq_pkg::ID_W];
            if (decision_q.size() == 0)
            begin
                $error("unexpected decision transfer: next_id %0d, next_valid %0d",
                       got.next_id, got.next_valid);
                mismatch_count++;
            end
            else
            begin
                want = decision_q.pop_front();
                if (got.next_id !== want.next_id)
                begin
                    $error("next_id mismatch: expected %0d, actual %0d",
                           want.next_id, got.next_id);
                    mismatch_count++;
                end
                if (got.next_valid !== want.next_valid)
                begin
                    $error("next_valid mismatch: expected %0d, actual %0d",
                           want.next_valid, got.next_valid);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_idle_dispatch();
        test_new_process();
        test_timer_demotion();
        test_io_and_finish();
        test_unknown_command();
        test_full_queue();
        wait_all_results();
        test_backpressure();
        test_random_traffic(400, 29, 73);
        test_random_traffic(400, 73, 29);
        test_random_traffic(400, 0, 0);

        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
